// File: sv/hhd_pkg.sv
// ----------------------------------------------------------------------------
// hhd_pkg
// Types and constants shared by the heap-tree Huffman decoder.
// ----------------------------------------------------------------------------
package hhd_pkg;

    localparam int unsigned NODE_INDEX_BITS_DEF = 12;
    localparam int unsigned ENTRY_W             = 12;
    localparam int unsigned SYM_W               = 8;
    localparam int unsigned BYTE_W              = 8;
    localparam int unsigned CNT_W               = 32;
    localparam int unsigned BIT_CNT_W           = 3;

    // first code bit of a packed byte
    localparam logic [BYTE_W-1:0] FIRST_BIT = 8'h80;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_CODE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               command;
        logic [ENTRY_W-1:0] entry_index;
        logic               entry_is_leaf;
        logic [SYM_W-1:0]   entry_symbol;
        logic [BYTE_W-1:0]  packed_byte;
    } in_item_t;

    typedef struct packed
    {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
        logic             error;
    } out_item_t;

    // walker -> node store
    typedef struct packed
    {
        logic             wr_en;
        logic             wr_is_leaf;
        logic [SYM_W-1:0] wr_symbol;
        logic             rd_en;
    } mem_ctrl_t;

    // node store -> walker
    typedef struct packed
    {
        logic             busy;
        logic             rd_internal;
        logic [SYM_W-1:0] rd_symbol;
    } mem_stat_t;

endpackage

// File: sv/hhd_node_store.sv
// ----------------------------------------------------------------------------
// hhd_node_store
// Node table: internal-flag and symbol memories, one read port each with
// registered data, plus the post-reset sweep that marks every node internal.
// ----------------------------------------------------------------------------
module hhd_node_store #(
    parameter int unsigned NODE_INDEX_BITS = hhd_pkg::NODE_INDEX_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hhd_pkg::mem_ctrl_t         ctrl,
    input  logic [NODE_INDEX_BITS-1:0] wr_addr,
    input  logic [NODE_INDEX_BITS-1:0] rd_addr,
    output hhd_pkg::mem_stat_t         stat
);

    localparam int unsigned DEPTH = 1 << NODE_INDEX_BITS;

    logic                       mem_internal [DEPTH];
    logic [hhd_pkg::SYM_W-1:0]  mem_symbol   [DEPTH];

    logic                       clr_busy_reg;
    logic                       clr_busy_next;
    logic [NODE_INDEX_BITS-1:0] clr_cnt_reg;
    logic [NODE_INDEX_BITS-1:0] clr_cnt_next;

    logic                       int_we;
    logic [NODE_INDEX_BITS-1:0] int_wa;
    logic                       int_wd;

    logic                       rd_internal_reg;
    logic [hhd_pkg::SYM_W-1:0]  rd_symbol_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {NODE_INDEX_BITS{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            int_we = 1'b1;
            int_wa = clr_cnt_reg;
            int_wd = 1'b1;
        end
        else
        begin
            int_we = ctrl.wr_en;
            int_wa = wr_addr;
            int_wd = !ctrl.wr_is_leaf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (int_we)
        begin
            mem_internal[int_wa] <= int_wd;
        end
        if (ctrl.rd_en)
        begin
            rd_internal_reg <= mem_internal[rd_addr];
        end
    end

    // symbols are never cleared: a leaf always comes with its symbol
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_symbol[wr_addr] <= ctrl.wr_symbol;
        end
        if (ctrl.rd_en)
        begin
            rd_symbol_reg <= mem_symbol[rd_addr];
        end
    end

    assign stat.busy        = clr_busy_reg;
    assign stat.rd_internal = rd_internal_reg;
    assign stat.rd_symbol   = rd_symbol_reg;

endmodule

// File: sv/hhd_walker.sv
// ----------------------------------------------------------------------------
// hhd_walker
// Tree-walk sequencer: one node table read per code bit, a held result slot
// so the final result of a byte can be flagged, and the output register.
// ----------------------------------------------------------------------------
module hhd_walker #(
    parameter int unsigned NODE_INDEX_BITS = hhd_pkg::NODE_INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hhd_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hhd_pkg::out_item_t          out_data,
    input  logic [hhd_pkg::CNT_W-1:0]   symbol_total,
    output hhd_pkg::mem_ctrl_t          mem_ctrl,
    output logic [NODE_INDEX_BITS-1:0]  wr_addr,
    output logic [NODE_INDEX_BITS-1:0]  rd_addr,
    input  hhd_pkg::mem_stat_t          mem_stat
);

    localparam int unsigned EW = (NODE_INDEX_BITS > hhd_pkg::ENTRY_W) ?
                                 NODE_INDEX_BITS : hhd_pkg::ENTRY_W;
    localparam logic [EW:0] TABLE_SIZE = (EW+1)'(1) << NODE_INDEX_BITS;
    localparam logic [NODE_INDEX_BITS-1:0] ROOT = NODE_INDEX_BITS'(1);
    localparam logic [hhd_pkg::BIT_CNT_W-1:0] LAST_BIT = '1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t                            state_reg, state_next;
    logic [NODE_INDEX_BITS-1:0]        cur_reg, cur_next;
    logic [hhd_pkg::CNT_W-1:0]         emitted_reg, emitted_next;
    logic [hhd_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic [hhd_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [NODE_INDEX_BITS-1:0]        addr_reg, addr_next;
    logic                              ovf_reg, ovf_next;
    logic                              pend_valid_reg, pend_valid_next;
    hhd_pkg::out_item_t                pend_reg, pend_next;
    logic                              out_valid_reg, out_valid_next;
    hhd_pkg::out_item_t                out_reg, out_next;

    logic                              accept;
    logic [EW:0]                       idx_ext;
    logic                              idx_in_range;
    logic                              is_leaf;
    logic                              has_result;
    logic [hhd_pkg::CNT_W-1:0]         emitted_inc;
    logic                              reached;
    logic                              out_free;
    logic                              push;
    hhd_pkg::out_item_t                push_item;
    hhd_pkg::out_item_t                new_res;
    logic [NODE_INDEX_BITS-1:0]        base;
    logic                              code_bit;

    assign in_ready     = (state_reg == S_IDLE) && !mem_stat.busy;
    assign accept       = in_valid && in_ready;
    assign idx_ext      = (EW+1)'(in_data.entry_index);
    assign idx_in_range = idx_ext < TABLE_SIZE;
    assign is_leaf      = !ovf_reg && !mem_stat.rd_internal;
    assign has_result   = ovf_reg || is_leaf;
    assign emitted_inc  = emitted_reg + 1'b1;
    assign reached      = emitted_inc >= symbol_total;
    assign out_free     = !out_valid_reg || out_ready;
    assign base         = has_result ? ROOT : addr_reg;
    assign code_bit     = (byte_reg & hhd_pkg::FIRST_BIT) != '0;

    always_comb
    begin
        new_res.symbol   = ovf_reg ? '0 : mem_stat.rd_symbol;
        new_res.last     = 1'b0;
        new_res.done_res = is_leaf && reached;
        new_res.error    = ovf_reg;
    end

    assign wr_addr             = idx_ext[NODE_INDEX_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        emitted_next    = emitted_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        addr_next       = addr_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_item       = pend_reg;
        mem_ctrl.wr_en      = 1'b0;
        mem_ctrl.wr_is_leaf = in_data.entry_is_leaf;
        mem_ctrl.wr_symbol  = in_data.entry_symbol;
        mem_ctrl.rd_en      = 1'b0;
        rd_addr         = {base[NODE_INDEX_BITS-2:0], code_bit};

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = {cur_reg[NODE_INDEX_BITS-2:0],
                           in_data.packed_byte[hhd_pkg::BYTE_W-1]};
                if (accept)
                begin
                    if (in_data.command == hhd_pkg::CMD_LOAD)
                    begin
                        mem_ctrl.wr_en = idx_in_range;
                    end
                    else if (emitted_reg < symbol_total)
                    begin
                        mem_ctrl.rd_en = 1'b1;
                        addr_next      = rd_addr;
                        ovf_next       = cur_reg[NODE_INDEX_BITS-1];
                        byte_next      = in_data.packed_byte << 1;
                        bit_cnt_next   = '0;
                        state_next     = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // a new result displaces the held one into the output register
                if (!(has_result && pend_valid_reg && !out_free))
                begin
                    if (has_result)
                    begin
                        push            = pend_valid_reg;
                        pend_next       = new_res;
                        pend_valid_next = 1'b1;
                    end
                    if (is_leaf)
                    begin
                        emitted_next = emitted_inc;
                    end
                    cur_next     = base;
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if ((bit_cnt_reg == LAST_BIT) || (is_leaf && reached))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        mem_ctrl.rd_en = 1'b1;
                        addr_next      = rd_addr;
                        ovf_next       = base[NODE_INDEX_BITS-1];
                        byte_next      = byte_reg << 1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_item.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_item;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= ROOT;
            emitted_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            emitted_reg    <= emitted_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        bit_cnt_reg <= bit_cnt_next;
        addr_reg    <= addr_next;
        ovf_reg     <= ovf_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        mem_stat.busy |-> !in_ready)
        else $error("item accepted during node table sweep");

    a_idle_no_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind after a byte");

    a_error_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.error) |-> (out_reg.symbol == '0 && !out_reg.done_res))
        else $error("error result carries symbol or done flag");

    a_stall_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && has_result && pend_valid_reg && !out_free)
        |=> $stable(addr_reg) && $stable(emitted_reg))
        else $error("walk advanced while output stalled");

endmodule

// File: sv/heap_tree_huffman_decoder.sv
// ----------------------------------------------------------------------------
// heap_tree_huffman_decoder
// Huffman decoder walking a heap-ordered code tree held in a node table.
// ----------------------------------------------------------------------------
// Load transactions (command 0) write one node of the tree: leaf flag and
// symbol at a heap index; indices beyond the table are dropped. Code
// transactions (command 1) carry eight code bits, MSB first. Node n has
// children 2n (bit 0) and 2n+1 (bit 1); the walk starts at node 1, emits a
// result on each leaf and restarts at node 1. A child index past the table
// gives an error result (symbol 0) and restarts the walk. The last result
// of each code byte has last set. Once symbol_total symbols are out, code
// bytes give nothing and spare bits are dropped; the emitted count is only
// cleared by reset. After reset the node table is swept to "all
// internal" node by node, with in_ready low throughout (cfg writes still
// taken). A code byte is handled in steps: accepting it and issuing the
// first read, a walk step for each bit (each bit needs the registered node
// table read of the previous one), and releasing the held final result;
// the walk ends early when the symbol count is reached and stalls while
// out_ready holds results back. The decoder works on one byte at a time.
// ----------------------------------------------------------------------------
module heap_tree_huffman_decoder #(
    parameter int unsigned NODE_INDEX_BITS = hhd_pkg::NODE_INDEX_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hhd_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output hhd_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  logic [hhd_pkg::CNT_W-1:0] cfg_wdata
);

    // symbol count limit, to be written only while idle; the block does not enforce this
    logic [hhd_pkg::CNT_W-1:0]  symbol_total_reg;
    logic [hhd_pkg::CNT_W-1:0]  symbol_total_next;

    hhd_pkg::mem_ctrl_t         mem_ctrl;
    hhd_pkg::mem_stat_t         mem_stat;
    logic [NODE_INDEX_BITS-1:0] wr_addr;
    logic [NODE_INDEX_BITS-1:0] rd_addr;

    assign symbol_total_next = cfg_we ? cfg_wdata : symbol_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_total_reg <= '0;
        end
        else
        begin
            symbol_total_reg <= symbol_total_next;
        end
    end

    // sequencer: per-bit walk, result hold and output register
    hhd_walker #(
        .NODE_INDEX_BITS (NODE_INDEX_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .symbol_total (symbol_total_reg),
        .mem_ctrl     (mem_ctrl),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .mem_stat     (mem_stat)
    );

    // node table with registered read data
    hhd_node_store #(
        .NODE_INDEX_BITS (NODE_INDEX_BITS)
    ) u_node_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mem_ctrl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .stat    (mem_stat)
    );

endmodule

// File: tb/heap_tree_huffman_decoder_test.sv
// ----------------------------------------------------------------------------
// heap_tree_huffman_decoder_test
// Self-checking bench for the heap-tree Huffman decoder.
// ----------------------------------------------------------------------------
// Random code trees are loaded in heap order, and code bytes are then pushed
// through the tree. A scoreboard keeps its own copy of the node table, the
// walk position and the symbol count. For each accepted transaction it
// predicts the decoded symbols and any overflow errors. Each result taken
// from the block is checked field by field against the oldest prediction.
// Both handshakes stall at random. The symbol count register is changed
// between phases: zero, all ones, and just above the current count so that
// the stop condition is exercised.
// ----------------------------------------------------------------------------
module heap_tree_huffman_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NODE_BITS     = hhd_pkg::NODE_INDEX_BITS_DEF;
    localparam int unsigned NODE_COUNT    = 1 << NODE_BITS;
    localparam time         HALF_PERIOD   = 6ns;
    localparam int          RESET_CYCLES  = 10;
    // allow a code byte time to finish before touching the register once
    // nothing more is expected
    localparam int          SETTLE_CYCLES = 16;
    localparam int          TOTAL_ITEMS   = 170;   // checked between trees, so the last tree overshoots
    localparam int          GAP_PERCENT   = 31;
    localparam int          CYCLE_LIMIT   = 500_000;

    typedef logic [hhd_pkg::ENTRY_W-1:0] entry_t;
    typedef logic [hhd_pkg::SYM_W-1:0]   sym_t;
    typedef logic [hhd_pkg::BYTE_W-1:0]  byte_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow of the node table and walker, queue of predictions
    // ------------------------------------------------------------------------
    class huffman_scoreboard;
        bit                          node_is_internal [NODE_COUNT];
        logic [hhd_pkg::SYM_W-1:0]   node_symbol      [NODE_COUNT];
        int unsigned                 walk_node;
        int unsigned                 symbol_total;
        int unsigned                 symbols_out;
        hhd_pkg::out_item_t          pending_results [$];
        int                          mismatches;

        function new();
            foreach (node_is_internal[i])
            begin
                node_is_internal[i] = 1'b1;
                node_symbol[i]      = '0;
            end
            walk_node    = 1;
            symbol_total = 0;
            symbols_out  = 0;
            mismatches   = 0;
        endfunction

        // Called once per accepted input transaction.
        function void note_input(hhd_pkg::in_item_t item);
            int unsigned        child;
            int                 k;
            int                 first;
            hhd_pkg::out_item_t res;

            if (item.command == hhd_pkg::CMD_LOAD)
            begin
                // symbol is stored even for an internal node
                node_is_internal[item.entry_index] = !item.entry_is_leaf;
                node_symbol[item.entry_index]      = item.entry_symbol;
                return;
            end

            first = pending_results.size();
            // MSB first; stop as soon as the symbol count is reached
            for (k = hhd_pkg::BYTE_W - 1; k >= 0 && symbols_out < symbol_total; k--)
            begin
                child = walk_node * 2 + item.packed_byte[k];
                res   = '0;
                if (child >= NODE_COUNT)
                begin
                    // walked off the bottom of the table
                    res.error = 1'b1;
                    pending_results.push_back(res);
                    walk_node = 1;
                end
                else if (!node_is_internal[child])
                begin
                    symbols_out++;
                    res.symbol   = node_symbol[child];
                    res.done_res = (symbols_out >= symbol_total);
                    pending_results.push_back(res);
                    walk_node = 1;
                end
                else
                begin
                    walk_node = child;
                end
            end

            // flag the final result of this byte
            if (pending_results.size() > first)
            begin
                res      = pending_results.pop_back();
                res.last = 1'b1;
                pending_results.push_back(res);
            end
        endfunction

        // Called once per accepted output transaction.
        function void check_result(hhd_pkg::out_item_t got);
            hhd_pkg::out_item_t want;

            if (pending_results.size() == 0)
            begin
                $error("unexpected result: symbol %02h last %0b done_res %0b error %0b",
                       got.symbol, got.last, got.done_res, got.error);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.symbol !== want.symbol)
            begin
                $error("symbol: expected %02h, got %02h", want.symbol, got.symbol);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
                mismatches++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    hhd_pkg::in_item_t           in_data   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    hhd_pkg::out_item_t          out_data;
    logic                        cfg_we    = 1'b0;
    logic [hhd_pkg::CNT_W-1:0]   cfg_wdata = '0;

    huffman_scoreboard  book      = new();
    int                 items_sent = 0;
    int                 cycle_count = 0;
    // when set, neither side idles
    bit                 no_gaps   = 1'b0;

    heap_tree_huffman_decoder #(
        .NODE_INDEX_BITS (NODE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("heap_tree_huffman_decoder test failed");
            $finish;
        end
    end

    // Result side: sample on the edge, then choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(out_data);
        out_ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Load transaction; the unused code byte carries noise.
    function automatic hhd_pkg::in_item_t make_load(entry_t idx, bit is_leaf, sym_t sym);
        hhd_pkg::in_item_t item;
        item.command       = hhd_pkg::CMD_LOAD;
        item.entry_index   = idx;
        item.entry_is_leaf = is_leaf;
        item.entry_symbol  = sym;
        item.packed_byte   = byte_t'($urandom_range(255));
        return item;
    endfunction

    // Code transaction; the unused entry fields carry noise.
    function automatic hhd_pkg::in_item_t make_code(byte_t code_bits);
        hhd_pkg::in_item_t item;
        item.command       = hhd_pkg::CMD_CODE;
        item.entry_index   = entry_t'($urandom_range(NODE_COUNT - 1));
        item.entry_is_leaf = 1'($urandom_range(1));
        item.entry_symbol  = sym_t'($urandom_range(255));
        item.packed_byte   = code_bits;
        return item;
    endfunction

    // Present one transaction and hold it until taken. Entered and left on
    // a rising edge; valid is left high so back-to-back items need no drop.
    task automatic send_item(input hhd_pkg::in_item_t item);
        no_gaps = (items_sent >= 90 && items_sent < 140);
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_input(item);
        items_sent++;
    endtask

    // Wait until every predicted result is out and the block has gone quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever done with the block idle.
    task automatic write_total(input logic [hhd_pkg::CNT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        book.symbol_total = value;
    endtask

    // Grow a random prefix tree from node 1 by splitting frontier nodes,
    // then write its internal nodes and leaves. Internal nodes are written
    // explicitly so that leaves left over from earlier trees are cleared.
    // With a hole, one leaf is written as internal instead, leaving a path
    // that falls through to stale entries or off the end of the table.
    task automatic load_new_tree(input int leaf_goal, input bit with_hole);
        int unsigned frontier [$];
        int unsigned inner [$];
        int unsigned n;
        int          pick;
        int          hole;

        frontier.push_back(2);
        frontier.push_back(3);
        inner.push_back(1);
        while (frontier.size() < leaf_goal)
        begin
            // half the time keep deepening the newest branch: long codes
            pick = $urandom_range(1) ? frontier.size() - 1
                                     : $urandom_range(frontier.size() - 1);
            n = frontier[pick];
            if (n < NODE_COUNT / 2)
            begin
                frontier.delete(pick);
                frontier.push_back(2 * n);
                frontier.push_back(2 * n + 1);
                inner.push_back(n);
            end
        end
        hole = with_hole ? $urandom_range(frontier.size() - 1) : -1;

        foreach (inner[i])
            send_item(make_load(entry_t'(inner[i]), 1'b0, sym_t'($urandom_range(255))));
        foreach (frontier[i])
            send_item(make_load(entry_t'(frontier[i]), i != hole,
                                sym_t'($urandom_range(255))));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int run_len;
        int pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // -- directed part -------------------------------------------------
        // count of zero: nothing is decoded at all
        write_total('0);
        send_item(make_code(8'hFF));
        // table extremes, and node 1 as a leaf (never tested by the walk)
        send_item(make_load(12'd0,    1'b1, 8'h00));
        send_item(make_load(12'hFFF,  1'b1, 8'hFF));
        send_item(make_load(12'd1,    1'b1, 8'h77));

        write_total('1);
        // empty tree: twelve bits down one path overflow the table
        send_item(make_code(8'h00));
        send_item(make_code(8'hFF));

        // small tree: 0 -> 3C, 10 -> C3, 110 -> 5A, 111... deeper
        send_item(make_load(12'd2,  1'b1, 8'h3C));
        send_item(make_load(12'd6,  1'b1, 8'hC3));
        send_item(make_load(12'd14, 1'b1, 8'h5A));
        send_item(make_load(12'd3,  1'b0, 8'hEE));
        send_item(make_load(12'd7,  1'b0, 8'h11));

        send_item(make_code(8'h00));   // finishes the pending walk
        send_item(make_code(8'h00));   // eight results from one byte
        send_item(make_code(8'hFF));
        send_item(make_code(8'hFF));   // reaches the leaf at the last node
        send_item(make_code(8'hB6));
        send_item(make_code(8'h55));

        // stop after three more symbols; spare bits and later bytes dropped
        write_total(book.symbols_out + 3);
        send_item(make_code(8'h00));
        send_item(make_code(8'h00));
        write_total('1);

        // -- random part ---------------------------------------------------
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(99) < 40)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    write_total('0);
                else if (pick < 4)
                    write_total(book.symbols_out + $urandom_range(12, 1));
                else
                    write_total('1);
            end

            load_new_tree($urandom_range(16, 2), $urandom_range(3) == 0);

            run_len = $urandom_range(14, 4);
            repeat (run_len)
            begin
                // mostly code bytes through the fresh tree, some stray loads
                if ($urandom_range(9) == 0)
                    send_item(make_load(entry_t'($urandom_range(NODE_COUNT - 1)),
                                        1'($urandom_range(1)),
                                        sym_t'($urandom_range(255))));
                else
                    send_item(make_code(byte_t'($urandom_range(255))));
            end
        end
        no_gaps = 1'b0;

        drain();
        if (book.mismatches == 0 && book.pending_results.size() == 0)
            $display("heap_tree_huffman_decoder test passed");
        else
            $display("heap_tree_huffman_decoder test failed");
        $finish;
    end

endmodule
